// ===== hdl/rjq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_pkg
// Shared types, codes and constants of the ring job queue.
// ----------------------------------------------------------------------------
package rjq_pkg;

	localparam int TAG_W     = 64;
	localparam int PAGE_W    = 8;
	localparam int ACTION_W  = 2;
	localparam int STATUS_W  = 3;
	localparam int DEPTH_DEF = 16;

	localparam logic [PAGE_W-1:0] MAX_PAGES_RST = 8'd50;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQ    = 2'd0,
		ACT_DEQ    = 2'd1,
		ACT_CANCEL = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 3'd0,
		STS_PAGES    = 3'd1,
		STS_FULL     = 3'd2,
		STS_EMPTY    = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ,
		ST_SEARCH,
		ST_SHIFT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [TAG_W-1:0]    tag;
		logic [PAGE_W-1:0]   pages;
	} res_t;

endpackage

// ===== hdl/rjq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_if
// Valid/ready channels for queue commands and queue responses.
// ----------------------------------------------------------------------------
interface rjq_cmd_if import rjq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [TAG_W-1:0]    job_tag;
	logic [PAGE_W-1:0]   page_count;

	modport source (output valid, output action, output job_tag, output page_count,
		input ready);
	modport sink (input valid, input action, input job_tag, input page_count,
		output ready);
endinterface

interface rjq_rsp_if import rjq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [TAG_W-1:0]    job_tag_out;
	logic [PAGE_W-1:0]   page_count_out;

	modport source (output valid, output status, output job_tag_out,
		output page_count_out, input ready);
	modport sink (input valid, input status, input job_tag_out,
		input page_count_out, output ready);
endinterface

// ===== hdl/rjq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rjq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/rjq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_ctrl
// Sequencer around the slot RAM: enqueue, dequeue, cancel search and shift, and clear.
// ----------------------------------------------------------------------------
module rjq_ctrl import rjq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rjq_cmd_if.sink           cmd,
	input  logic [PAGE_W-1:0] max_pages,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int SLOT_W = TAG_W + PAGE_W;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	function automatic logic [PTR_W-1:0] nxt_f(input logic [PTR_W-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	state_t state_q, state_d;
	logic [PTR_W-1:0] head_q, tail_q, cur_q;
	action_t act_q;
	logic [TAG_W-1:0] tag_q;
	logic [PAGE_W-1:0] pages_q;
	res_t res_q;

	logic ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [SLOT_W-1:0] ram_wdata, ram_rdata;

	logic empty, full, hit;
	logic [PTR_W-1:0] cur_nxt, cur_nxt2;

	assign empty    = (head_q == tail_q);
	assign full     = (nxt_f(tail_q) == head_q);
	assign cur_nxt  = nxt_f(cur_q);
	assign cur_nxt2 = nxt_f(cur_nxt);
	assign hit      = (ram_rdata[SLOT_W-1:PAGE_W] == tag_q);

	rjq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (act_q)
					ACT_DEQ:    state_d = empty ? ST_RESULT : ST_DEQ;
					ACT_CANCEL: state_d = empty ? ST_RESULT : ST_SEARCH;
					default:    state_d = ST_RESULT;
				endcase
			end
			ST_DEQ: state_d = ST_RESULT;
			ST_SEARCH: begin
				if (cur_nxt == tail_q) state_d = ST_RESULT;
				else if (hit)          state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (cur_nxt2 == tail_q) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and ram control
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESULT);
		res       = res_q;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {tag_q, pages_q};
		ram_re    = 1'b0;
		ram_raddr = head_q;
		case (state_q)
			ST_EXEC: begin
				case (act_q)
					ACT_ENQ: ram_we = (pages_q <= max_pages) && !full;
					ACT_DEQ: ram_re = !empty;
					ACT_CANCEL: ram_re = !empty;
					default: ram_re = 1'b0;
				endcase
			end
			ST_SEARCH: begin
				ram_re    = (cur_nxt != tail_q);
				ram_raddr = cur_nxt;
			end
			ST_SHIFT: begin
				// move the later job one slot toward the head
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = ram_rdata;
				ram_re    = (cur_nxt2 != tail_q);
				ram_raddr = cur_nxt2;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_EXEC: begin
					if (act_q == ACT_ENQ && pages_q <= max_pages && !full) begin
						tail_q <= nxt_f(tail_q);
					end else if (act_q == ACT_CLEAR) begin
						head_q <= '0;
						tail_q <= '0;
					end
				end
				ST_DEQ: head_q <= nxt_f(head_q);
				ST_SEARCH: begin
					if (hit && cur_nxt == tail_q) tail_q <= cur_q;
				end
				ST_SHIFT: begin
					if (cur_nxt2 == tail_q) tail_q <= cur_nxt;
				end
				default: head_q <= head_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					act_q   <= action_t'(cmd.action);
					tag_q   <= cmd.job_tag;
					pages_q <= cmd.page_count;
				end
			end
			ST_EXEC: begin
				res_q.tag   <= '0;
				res_q.pages <= '0;
				cur_q <= head_q;
				case (act_q)
					ACT_ENQ: begin
						if (pages_q > max_pages) res_q.status <= STS_PAGES;
						else if (full)           res_q.status <= STS_FULL;
						else                     res_q.status <= STS_OK;
					end
					ACT_DEQ, ACT_CANCEL: begin
						res_q.status <= empty ? STS_EMPTY : STS_OK;
					end
					default: res_q.status <= STS_OK;
				endcase
			end
			ST_DEQ: begin
				res_q.tag   <= ram_rdata[SLOT_W-1:PAGE_W];
				res_q.pages <= ram_rdata[PAGE_W-1:0];
			end
			ST_SEARCH: begin
				if (!hit) begin
					cur_q <= cur_nxt;
					if (cur_nxt == tail_q) res_q.status <= STS_NOTFOUND;
				end
			end
			ST_SHIFT: cur_q <= cur_nxt;
			default: cur_q <= cur_q;
		endcase
	end

endmodule

// ===== hdl/ring_job_queue_with_cancel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_job_queue_with_cancel
// Circular job queue with page limit, dequeue, cancel by tag and clear.
// ----------------------------------------------------------------------------
// One command is handled at a time; every command gives exactly one response
// transaction. Enqueue and clear go from the exec state to the result state,
// dequeue reads its slot in a dequeue state between them, and cancel walks
// the slots in search and shift states: the search visits slots from the
// head up to the match and the shift visits the slots after it. The walk is
// set by the single read port of the slot RAM, one slot per cycle. A new
// command is accepted once the previous response has moved into the output
// register. max_pages may only be written while no command is in flight.
// ----------------------------------------------------------------------------
module ring_job_queue_with_cancel import rjq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rjq_cmd_if.sink           cmd,
	rjq_rsp_if.source         rsp,
	input  logic              cfg_wr_en,
	input  logic [PAGE_W-1:0] cfg_wr_data
);

	logic [PAGE_W-1:0] max_pages_q;
	logic res_valid, res_ready;
	res_t res, out_q;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pages_q <= MAX_PAGES_RST;
		end else if (cfg_wr_en) begin
			max_pages_q <= cfg_wr_data;
		end
	end

	rjq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.max_pages (max_pages_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register frees the sequencer while the response waits
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.job_tag_out    = out_q.tag;
	assign rsp.page_count_out = out_q.pages;

endmodule

// ===== dv/ring_job_queue_with_cancel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_job_queue_with_cancel_checker
// Watches the command, response and register ports of the job queue. It
// keeps its own copy of the ring and the page limit, works out the response
// to every accepted command and compares each accepted response with the
// oldest one owed.
// ----------------------------------------------------------------------------
module ring_job_queue_with_cancel_checker import rjq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_ready,
	input  logic [ACTION_W-1:0] cmd_action,
	input  logic [TAG_W-1:0]    cmd_tag,
	input  logic [PAGE_W-1:0]   cmd_pages,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  logic [STATUS_W-1:0] rsp_status,
	input  logic [TAG_W-1:0]    rsp_tag,
	input  logic [PAGE_W-1:0]   rsp_pages,
	input  logic                cfg_wr_en,
	input  logic [PAGE_W-1:0]   cfg_wr_data,
	output int                  fail_cnt,
	output int                  owed_cnt
);

	localparam int SLOTS = DEPTH_DEF;

	logic [TAG_W-1:0]  job_tags  [SLOTS];
	logic [PAGE_W-1:0] job_pages [SLOTS];
	int                head;
	int                tail;
	logic [PAGE_W-1:0] page_limit;
	res_t              owed_replies [$];
	int                errors = 0;

	assign fail_cnt = errors;

	task automatic report(string field, logic [TAG_W-1:0] got, logic [TAG_W-1:0] want);
		errors++;
		$display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
	endtask

	function automatic int ring_next(int i);
		return (i + 1) % SLOTS;
	endfunction

	// updates the shadow ring and returns the response the command earns
	function automatic res_t apply_job_cmd(action_t act, logic [TAG_W-1:0] tag,
			logic [PAGE_W-1:0] pages);
		res_t r;
		int   cur;
		int   nxt;
		bit   hit;
		r.status = STS_OK;
		r.tag    = '0;
		r.pages  = '0;
		case (act)
			ACT_ENQ: begin
				// page limit is checked ahead of the full check
				if (pages > page_limit) begin
					r.status = STS_PAGES;
				end else if (ring_next(tail) == head) begin
					r.status = STS_FULL;
				end else begin
					job_tags[tail]  = tag;
					job_pages[tail] = pages;
					tail = ring_next(tail);
				end
			end
			ACT_DEQ: begin
				if (head == tail) begin
					r.status = STS_EMPTY;
				end else begin
					r.tag   = job_tags[head];
					r.pages = job_pages[head];
					head = ring_next(head);
				end
			end
			ACT_CANCEL: begin
				if (head == tail) begin
					r.status = STS_EMPTY;
				end else begin
					cur = head;
					hit = 0;
					while (cur != tail && !hit) begin
						if (job_tags[cur] == tag)
							hit = 1;
						else
							cur = ring_next(cur);
					end
					if (!hit) begin
						r.status = STS_NOTFOUND;
					end else begin
						// close the gap by pulling later jobs toward the head
						nxt = ring_next(cur);
						while (nxt != tail) begin
							job_tags[cur]  = job_tags[nxt];
							job_pages[cur] = job_pages[nxt];
							cur = nxt;
							nxt = ring_next(nxt);
						end
						tail = cur;
					end
				end
			end
			default: begin
				head = 0;
				tail = 0;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			head = 0;
			tail = 0;
			page_limit = MAX_PAGES_RST;
			owed_replies.delete();
			owed_cnt <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (owed_replies.size() == 0) begin
					report("unexpected response transaction", TAG_W'(rsp_status), '0);
				end else begin
					want = owed_replies.pop_front();
					if (rsp_status !== want.status)
						report("status", TAG_W'(rsp_status), TAG_W'(want.status));
					if (rsp_tag !== want.tag)
						report("job_tag_out", rsp_tag, want.tag);
					if (rsp_pages !== want.pages)
						report("page_count_out", TAG_W'(rsp_pages), TAG_W'(want.pages));
				end
			end
			if (cfg_wr_en)
				page_limit = cfg_wr_data;
			if (cmd_valid && cmd_ready)
				owed_replies.push_back(apply_job_cmd(action_t'(cmd_action), cmd_tag, cmd_pages));
			owed_cnt <= owed_replies.size();
		end
	end

endmodule

// ===== dv/ring_job_queue_with_cancel_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_job_queue_with_cancel_tb
// Drives directed and random job commands into the ring job queue under
// several page limits, with random gaps on the command side and random
// back-pressure on the response side; the checker beside the block does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module ring_job_queue_with_cancel_tb;
	import rjq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 165;
	localparam int TAG_POOL    = 6;
	localparam int PHASES      = 7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [PAGE_W-1:0] cfg_wr_data = '0;
	logic [PAGE_W-1:0] cur_limit = MAX_PAGES_RST;
	logic [TAG_W-1:0]  tag_pool [TAG_POOL];
	bit                calm = 1'b0;
	int                hold = 0;
	int                cycles = 0;
	int                fail_cnt;
	int                owed_cnt;

	rjq_cmd_if cmd_ch ();
	rjq_rsp_if rsp_ch ();

	ring_job_queue_with_cancel #(.DEPTH(DEPTH_DEF)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	ring_job_queue_with_cancel_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_ch.valid),
		.cmd_ready  (cmd_ch.ready),
		.cmd_action (cmd_ch.action),
		.cmd_tag    (cmd_ch.job_tag),
		.cmd_pages  (cmd_ch.page_count),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_status (rsp_ch.status),
		.rsp_tag    (rsp_ch.job_tag_out),
		.rsp_pages  (rsp_ch.page_count_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_cnt   (fail_cnt),
		.owed_cnt   (owed_cnt)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ring_job_queue_with_cancel_tb NOT OK");
			$finish;
		end
	end

	// random response back-pressure in bursts, off while calm
	always @(posedge clk) begin
		if (calm) begin
			rsp_ch.ready <= 1'b1;
		end else if (hold > 0) begin
			rsp_ch.ready <= 1'b0;
			hold <= hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_ch.ready <= 1'b0;
			hold <= $urandom_range(0, 2);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_cmd(action_t act, logic [TAG_W-1:0] tag, logic [PAGE_W-1:0] pages);
		if (!calm && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= act;
		cmd_ch.job_tag    <= tag;
		cmd_ch.page_count <= pages;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// hold the command side until every owed response transaction is back
	task automatic drain_replies();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (owed_cnt != 0);
	endtask

	task automatic set_page_limit(logic [PAGE_W-1:0] lim);
		drain_replies();
		repeat (2) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_limit = lim;
	endtask

	// mostly tags from a small pool so that cancels hit and duplicates occur
	function automatic logic [TAG_W-1:0] pick_tag();
		if ($urandom_range(0, 4) == 0)
			return {$urandom, $urandom};
		return tag_pool[$urandom_range(0, TAG_POOL - 1)];
	endfunction

	task automatic run_phase(int items, bit pause_mid);
		int                mode;
		int                r;
		int                enq_lim;
		int                deq_lim;
		int                can_lim;
		action_t           act;
		logic [PAGE_W-1:0] pages;
		for (int n = 0; n < items; n++) begin
			// fill-heavy, drain-heavy or mixed stretches
			if (n % 32 == 0)
				mode = $urandom_range(0, 2);
			if (pause_mid && n == items / 2)
				drain_replies();
			enq_lim = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
			deq_lim = (mode == 0) ? 80 : (mode == 1) ? 60 : 70;
			can_lim = (mode == 0) ? 98 : (mode == 1) ? 97 : 96;
			r = $urandom_range(0, 99);
			if (r < enq_lim)
				act = ACT_ENQ;
			else if (r < deq_lim)
				act = ACT_DEQ;
			else if (r < can_lim)
				act = ACT_CANCEL;
			else
				act = ACT_CLEAR;
			if ($urandom_range(0, 4) == 0)
				pages = PAGE_W'($urandom_range(0, 255));
			else
				pages = PAGE_W'($urandom_range(0, int'(cur_limit)));
			send_cmd(act, pick_tag(), pages);
		end
	endtask

	initial begin
		logic [PAGE_W-1:0] limits [PHASES];
		cmd_ch.valid      = 1'b0;
		cmd_ch.action     = '0;
		cmd_ch.job_tag    = '0;
		cmd_ch.page_count = '0;
		rsp_ch.ready      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, page limit, zero and all-ones tags, duplicates
		send_cmd(ACT_DEQ, '1, 8'd0);
		send_cmd(ACT_CANCEL, '0, 8'd0);
		send_cmd(ACT_ENQ, '1, MAX_PAGES_RST + 8'd1);
		send_cmd(ACT_ENQ, '1, MAX_PAGES_RST);
		send_cmd(ACT_ENQ, '0, 8'd0);
		send_cmd(ACT_ENQ, '1, 8'd3);
		send_cmd(ACT_CANCEL, 64'h5555_5555_5555_5555, 8'd0);
		send_cmd(ACT_CANCEL, '1, 8'd0);
		send_cmd(ACT_DEQ, '0, 8'd0);
		send_cmd(ACT_DEQ, '0, 8'd0);
		// fill across the wrap, then full and oversized-while-full
		for (int i = 0; i < DEPTH_DEF - 1; i++)
			send_cmd(ACT_ENQ, 64'hC0DE_0000_0000_0000 | TAG_W'(i), PAGE_W'(i * 3));
		send_cmd(ACT_ENQ, 64'hFEED_0000_0000_0001, 8'd1);
		send_cmd(ACT_ENQ, 64'hFEED_0000_0000_0002, 8'd255);
		send_cmd(ACT_CANCEL, 64'hC0DE_0000_0000_0007, 8'd0);
		send_cmd(ACT_CLEAR, '0, 8'd0);
		send_cmd(ACT_DEQ, '0, 8'd0);

		limits = '{8'd255, 8'd0, 8'd1, 8'd128, PAGE_W'($urandom_range(2, 254)),
			MAX_PAGES_RST, 8'd254};
		for (int ph = 0; ph < PHASES; ph++) begin
			set_page_limit(limits[ph]);
			for (int i = 0; i < TAG_POOL; i++)
				tag_pool[i] = {$urandom, $urandom};
			calm = (ph == PHASES - 1);
			run_phase(PHASE_ITEMS, ph == 2);
		end

		drain_replies();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("ring_job_queue_with_cancel_tb OK");
		else
			$display("ring_job_queue_with_cancel_tb NOT OK");
		$finish;
	end

endmodule

// ===== ring_job_queue_with_cancel.f =====
hdl/rjq_pkg.sv
hdl/rjq_if.sv
hdl/rjq_ram.sv
hdl/rjq_ctrl.sv
hdl/ring_job_queue_with_cancel.sv
dv/ring_job_queue_with_cancel_checker.sv
dv/ring_job_queue_with_cancel_tb.sv
